// File: rtl/wsfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer package
// Shared result type, parse phase encoding and header constants.
// ----------------------------------------------------------------------------
package wsfd_pkg;

    localparam int LEN_W = 63;

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [2:0] KEY_BYTES   = 3'd4;

    typedef enum logic [4:0] {
        PH_FIRST   = 5'b00001,
        PH_SECOND  = 5'b00010,
        PH_EXT     = 5'b00100,
        PH_KEY     = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } t_phase;

    typedef struct packed {
        logic              kind;
        logic              fin;
        logic [2:0]        reserved_bits;
        logic [3:0]        frame_opcode;
        logic              masked;
        logic [LEN_W-1:0]  frame_len;
        logic [7:0]        payload_byte;
        logic              last;
    } t_result;

endpackage

// File: rtl/wsfd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame header parser
// Holds the parse state and turns each accepted byte into at most one result.
// ----------------------------------------------------------------------------
module wsfd_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_rx_byte,
    output logic              o_res_valid,
    output wsfd_pkg::t_result o_res
);
    import wsfd_pkg::*;

    t_phase            r_phase, n_phase;
    logic [7:0]        r_first, n_first;
    logic              r_mask_flag, n_mask_flag;
    logic [3:0]        r_ext_left, n_ext_left;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [2:0]        r_key_left, n_key_left;
    logic [31:0]       r_key, n_key;
    logic [1:0]        r_key_idx, n_key_idx;
    logic [LEN_W-1:0]  r_remaining, n_remaining;

    logic [3:0]        ext_dec;
    logic [2:0]        key_dec;
    logic [7:0]        key_byte;
    logic              emit_hdr;
    logic              hdr_last;

    always_comb begin
        ext_dec = (r_ext_left != 4'd0) ? r_ext_left - 4'd1 : r_ext_left;
        key_dec = (r_key_left != 3'd0) ? r_key_left - 3'd1 : r_key_left;
        case (r_key_idx)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
        if (!r_mask_flag) begin
            key_byte = 8'h00;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_first     = r_first;
        n_mask_flag = r_mask_flag;
        n_ext_left  = r_ext_left;
        n_len       = r_len;
        n_key_left  = r_key_left;
        n_key       = r_key;
        n_key_idx   = r_key_idx;
        n_remaining = r_remaining;
        emit_hdr    = 1'b0;
        hdr_last    = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_accept) begin
            case (r_phase)
                PH_FIRST: begin
                    n_first     = i_rx_byte;
                    n_mask_flag = 1'b0;
                    n_key       = '0;
                    n_len       = '0;
                    n_ext_left  = '0;
                    n_key_left  = '0;
                    n_phase     = PH_SECOND;
                end
                PH_SECOND: begin
                    n_mask_flag = i_rx_byte[7];
                    n_len       = '0;
                    if (i_rx_byte[6:0] == LEN7_EXT16) begin
                        n_ext_left = EXT16_BYTES;
                        n_phase    = PH_EXT;
                    end else if (i_rx_byte[6:0] == LEN7_EXT64) begin
                        n_ext_left = EXT64_BYTES;
                        n_phase    = PH_EXT;
                    end else begin
                        n_len = {{(LEN_W-7){1'b0}}, i_rx_byte[6:0]};
                        if (i_rx_byte[7]) begin
                            n_key_left = KEY_BYTES;
                            n_phase    = PH_KEY;
                        end else begin
                            emit_hdr = 1'b1;
                        end
                    end
                end
                PH_EXT: begin
                    // The top bit of a 64-bit length falls off the 63-bit accumulator.
                    n_len      = {r_len[LEN_W-9:0], i_rx_byte};
                    n_ext_left = ext_dec;
                    if (ext_dec == 4'd0) begin
                        if (r_mask_flag) begin
                            n_key_left = KEY_BYTES;
                            n_phase    = PH_KEY;
                        end else begin
                            emit_hdr = 1'b1;
                        end
                    end
                end
                PH_KEY: begin
                    n_key      = {r_key[23:0], i_rx_byte};
                    n_key_left = key_dec;
                    if (key_dec == 3'd0) begin
                        emit_hdr = 1'b1;
                    end
                end
                PH_PAYLOAD: begin
                    o_res_valid          = 1'b1;
                    o_res.kind           = KIND_PAYLOAD;
                    o_res.fin            = r_first[7];
                    o_res.reserved_bits  = r_first[6:4];
                    o_res.frame_opcode   = r_first[3:0];
                    o_res.masked         = r_mask_flag;
                    o_res.frame_len      = r_len;
                    o_res.payload_byte   = i_rx_byte ^ key_byte;
                    o_res.last           = (r_remaining <= {{(LEN_W-1){1'b0}}, 1'b1});
                    n_key_idx            = r_key_idx + 2'd1;
                    if (r_remaining != '0) begin
                        n_remaining = r_remaining - {{(LEN_W-1){1'b0}}, 1'b1};
                    end
                    if (o_res.last) begin
                        n_phase = PH_FIRST;
                    end
                end
                default: begin
                    n_phase = PH_FIRST;
                end
            endcase

            if (emit_hdr) begin
                hdr_last             = (n_len == '0);
                o_res_valid          = 1'b1;
                o_res.kind           = KIND_HEADER;
                o_res.fin            = r_first[7];
                o_res.reserved_bits  = r_first[6:4];
                o_res.frame_opcode   = r_first[3:0];
                o_res.masked         = n_mask_flag;
                o_res.frame_len      = n_len;
                o_res.payload_byte   = 8'h00;
                o_res.last           = hdr_last;
                n_key_idx            = 2'd0;
                n_remaining          = n_len;
                n_phase              = hdr_last ? PH_FIRST : PH_PAYLOAD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_FIRST;
            r_first     <= '0;
            r_mask_flag <= 1'b0;
            r_ext_left  <= '0;
            r_len       <= '0;
            r_key_left  <= '0;
            r_key       <= '0;
            r_key_idx   <= '0;
            r_remaining <= '0;
        end else begin
            r_phase     <= n_phase;
            r_first     <= n_first;
            r_mask_flag <= n_mask_flag;
            r_ext_left  <= n_ext_left;
            r_len       <= n_len;
            r_key_left  <= n_key_left;
            r_key       <= n_key;
            r_key_idx   <= n_key_idx;
            r_remaining <= n_remaining;
        end
    end

endmodule

// File: rtl/wsfd_out_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket deframer result queue
// Two-entry output register with skid slot, so the input stall is registered.
// ----------------------------------------------------------------------------
module wsfd_out_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  wsfd_pkg::t_result i_res,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_stall,
    output wsfd_pkg::t_result o_res
);
    import wsfd_pkg::*;

    logic    r_v0, n_v0;
    logic    r_v1, n_v1;
    t_result r_d0, n_d0;
    t_result r_d1, n_d1;
    logic    pop;

    always_comb begin
        pop  = r_v0 && !i_stall;
        n_v0 = r_v0;
        n_v1 = r_v1;
        n_d0 = r_d0;
        n_d1 = r_d1;
        // A completed transfer moves the skid entry up to the output slot.
        if (pop) begin
            n_v0 = r_v1;
            n_d0 = r_d1;
            n_v1 = 1'b0;
        end
        if (i_push) begin
            if (!n_v0) begin
                n_v0 = 1'b1;
                n_d0 = i_res;
            end else begin
                n_v1 = 1'b1;
                n_d1 = i_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= n_v0;
            r_v1 <= n_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d0 <= n_d0;
        r_d1 <= n_d1;
    end

    assign o_full  = r_v1;
    assign o_valid = r_v0;
    assign o_res   = r_d0;

endmodule

// File: rtl/websocket_frame_deframer_unit.sv
// Each result is registered in the output queue before it appears on the output.
// Throughput: one byte per cycle while o_stall is low; the parse state updates within the accepting cycle.
// A two-entry output queue registers the input stall, raised only when both entries wait.
// Reset (synchronous, active low) returns the parser to the first header byte
// and empties the output queue.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses received frames byte by byte and emits header and unmasked payload results.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_kind,
    output logic        o_fin,
    output logic [2:0]  o_reserved_bits,
    output logic [3:0]  o_frame_opcode,
    output logic        o_masked,
    output logic [62:0] o_frame_len,
    output logic [7:0]  o_payload_byte,
    output logic        o_last
);
    import wsfd_pkg::*;

    logic    w_accept;
    logic    w_res_valid;
    t_result w_res;
    t_result w_out;
    logic    w_full;

    assign w_accept = i_valid && !w_full;
    assign o_stall  = w_full;

    wsfd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_rx_byte   (i_rx_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    wsfd_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_res   (w_res),
        .o_full  (w_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (w_out)
    );

    assign o_kind           = w_out.kind;
    assign o_fin            = w_out.fin;
    assign o_reserved_bits  = w_out.reserved_bits;
    assign o_frame_opcode   = w_out.frame_opcode;
    assign o_masked         = w_out.masked;
    assign o_frame_len      = w_out.frame_len;
    assign o_payload_byte   = w_out.payload_byte;
    assign o_last           = w_out.last;

`ifndef SYNTH
    a_full_implies_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("Skid entry held while the output slot is empty.");

    a_result_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> w_accept)
        else $error("Result produced without an accepted byte.");

    a_header_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && (w_res.kind == KIND_HEADER)) |-> (w_res.payload_byte == 8'h00))
        else $error("Header result carries a non-zero payload byte.");

    a_push_shows_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |=> o_valid)
        else $error("Pushed result did not reach the output.");
`endif

endmodule
